// File: hw/rtl/rfdw_pkg.sv
// rfdw_pkg: shared types and constants for the radio receive fifo drain watchdog
// no dependencies; imported by every module of the block

package rfdw_pkg;

  // field widths
  localparam int unsigned CountW  = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SlotOutW = 2;
  localparam int unsigned CfgIdxW = 8;

  // ring depth default
  localparam int unsigned RING_SLOTS_DEF = 4;

  // fifo status count mask
  localparam logic [ByteW-1:0] COUNT_MASK = 8'h7F;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_STALL_LIMIT = 8'd1;

  // configuration reset values
  localparam logic [ByteW-1:0] MAX_LENGTH_RST  = 8'd250;
  localparam logic [ByteW-1:0] STALL_LIMIT_RST = 8'd5;

  // saturation value of the watchdog counter
  localparam logic [ByteW-1:0] STALL_SAT = 8'd255;

  // opcodes
  localparam logic OP_POLL      = 1'b0;
  localparam logic OP_HOST_BUS  = 1'b1;

  // configuration values
  typedef struct packed {
    logic [ByteW-1:0] max_length;
    logic [ByteW-1:0] stall_limit;
  } cfg_t;

  // reception state, ring slot kept apart since its width follows a parameter
  typedef struct packed {
    logic              active_receive;
    logic [ByteW-1:0]  expected_length;
    logic [ByteW-1:0]  bytes_received;
    logic [CountW-1:0] previous_count;
    logic [ByteW-1:0]  stall_ticks;
  } rx_state_t;

  // one input item
  typedef struct packed {
    logic             opcode;
    logic [ByteW-1:0] fifo_status;
    logic [ByteW-1:0] length_byte;
  } item_in_t;

  // one result item
  typedef struct packed {
    logic [CountW-1:0]   read_count;
    logic [ByteW-1:0]    read_offset;
    logic                packet_started;
    logic                packet_done;
    logic [SlotOutW-1:0] done_slot;
    logic [ByteW-1:0]    done_length;
    logic                flush_and_restart;
    logic                restart_receive;
    logic                receiving;
  } item_out_t;

endpackage

// File: hw/rtl/rfdw_cfg.sv
// rfdw_cfg: configuration register file (max_length, stall_limit)
// depends on rfdw_pkg

module rfdw_cfg
  import rfdw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data,
  output cfg_t               cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_length  <= MAX_LENGTH_RST;
      cfg.stall_limit <= STALL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_LENGTH) begin
        cfg.max_length <= cfg_data;
      end
      if (cfg_index == CFG_STALL_LIMIT) begin
        cfg.stall_limit <= cfg_data;
      end
    end
  end

endmodule

// File: hw/rtl/rfdw_step.sv
// rfdw_step: combinational next state and result for one poll tick or host event
// depends on rfdw_pkg

module rfdw_step
  import rfdw_pkg::*;
#(
  parameter int unsigned RING_SLOTS = RING_SLOTS_DEF,
  localparam int unsigned SlotW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1
) (
  input  cfg_t             cfg,
  input  rx_state_t        st,
  input  logic [SlotW-1:0] slot,
  input  item_in_t         item,
  output rx_state_t        st_next,
  output logic [SlotW-1:0] slot_next,
  output item_out_t        res
);

  localparam logic [SlotW-1:0] SlotLast = SlotW'(RING_SLOTS - 1);

  logic [CountW-1:0] count;
  logic [ByteW:0]    reach;
  logic [ByteW-1:0]  remain;
  logic [CountW-1:0] take;
  logic [ByteW-1:0]  got;
  logic [ByteW-1:0]  stall_inc;
  logic              len_bad;

  always_comb begin
    count     = item.fifo_status[CountW-1:0];
    reach     = {1'b0, st.bytes_received} + {2'b0, count};
    remain    = st.expected_length - st.bytes_received;
    len_bad   = (item.length_byte == '0) || (item.length_byte > cfg.max_length);
    take      = '0;
    got       = st.bytes_received;
    stall_inc = st.stall_ticks;

    st_next   = st;
    slot_next = slot;
    res       = '0;

    if (item.opcode == OP_HOST_BUS) begin
      // host owns the bus, drop any partial packet
      st_next.active_receive = 1'b0;
    end else if (!st.active_receive) begin
      // listening: judge the length byte
      if (count != '0) begin
        if (len_bad) begin
          res.flush_and_restart = 1'b1;
        end else begin
          st_next.expected_length = item.length_byte;
          st_next.bytes_received  = '0;
          st_next.previous_count  = '0;
          st_next.stall_ticks     = '0;
          st_next.active_receive  = 1'b1;
          res.packet_started      = 1'b1;
        end
      end
    end else begin
      // receiving: size the burst read
      if (count != '0) begin
        if (reach >= {1'b0, st.expected_length}) begin
          if (st.expected_length > st.bytes_received) begin
            take = remain[CountW-1:0];
          end
        end else if (count > CountW'(1)) begin
          take = count - CountW'(1);
        end
        if (take != '0) begin
          res.read_count         = take;
          res.read_offset        = st.bytes_received;
          got                    = st.bytes_received + {1'b0, take};
          st_next.bytes_received = got;
          st_next.stall_ticks    = '0;
          stall_inc              = '0;
        end
      end
      // completion, watchdog, or count moved
      if (got >= st.expected_length) begin
        res.packet_done        = 1'b1;
        res.restart_receive    = 1'b1;
        slot_next              = (slot == SlotLast) ? '0 : slot + SlotW'(1);
        st_next.active_receive = 1'b0;
      end else if (count == st.previous_count) begin
        if (stall_inc != STALL_SAT) begin
          stall_inc = stall_inc + ByteW'(1);
        end
        st_next.stall_ticks = stall_inc;
        if (stall_inc > cfg.stall_limit) begin
          res.flush_and_restart  = 1'b1;
          st_next.active_receive = 1'b0;
        end
      end else begin
        st_next.previous_count = count;
        st_next.stall_ticks    = '0;
      end
    end

    // slot shown is the completed one, else the one now filling
    res.done_slot   = res.packet_done ? SlotOutW'(slot) : SlotOutW'(slot_next);
    res.done_length = st_next.expected_length;
    res.receiving   = st_next.active_receive;
  end

endmodule

// File: hw/rtl/radio_rx_fifo_drain_watchdog_top.sv
// radio_rx_fifo_drain_watchdog_top: input register, step logic, state and result register
// depends on rfdw_pkg, rfdw_cfg, rfdw_step

// Receive FIFO drain engine with stall watchdog. Every item is a poll tick
// (fifo status and first fifo byte) or a host-takes-bus event, and gives exactly
// one result item. An accepted item sits in an input register; in the cycle it
// moves on, the step logic updates the reception state and writes the result
// register. One item per cycle is sustained while out_stall stays low; each item
// passes through the input register and then the result register to its result.
// A stalled result register holds the item in the input register, and in_stall
// rises only when both are full and out_stall is high. Configuration writes are
// taken in any cycle (cfg_ready is tied high) and must only be made while idle.

module radio_rx_fifo_drain_watchdog_top
  import rfdw_pkg::*;
#(
  parameter int unsigned RING_SLOTS = RING_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic [ByteW-1:0]    fifo_status,
  input  logic [ByteW-1:0]    length_byte,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CountW-1:0]   read_count,
  output logic [ByteW-1:0]    read_offset,
  output logic                packet_started,
  output logic                packet_done,
  output logic [SlotOutW-1:0] done_slot,
  output logic [ByteW-1:0]    done_length,
  output logic                flush_and_restart,
  output logic                restart_receive,
  output logic                receiving,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [ByteW-1:0]    cfg_data
);

  localparam int unsigned SlotW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  cfg_t             cfg;
  item_in_t         in_q;
  logic             in_q_valid;
  rx_state_t        st;
  rx_state_t        st_next;
  logic [SlotW-1:0] slot;
  logic [SlotW-1:0] slot_next;
  item_out_t        res;
  item_out_t        out_q;
  logic             advance;

  rfdw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rfdw_step #(
    .RING_SLOTS (RING_SLOTS)
  ) u_step (
    .cfg       (cfg),
    .st        (st),
    .slot      (slot),
    .item      (in_q),
    .st_next   (st_next),
    .slot_next (slot_next),
    .res       (res)
  );

  // handshake: the item moves when the result register is free or draining
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q.opcode      <= opcode;
      in_q.fifo_status <= fifo_status;
      in_q.length_byte <= length_byte;
    end
  end

  // reception state
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= '0;
      slot <= '0;
    end else if (advance) begin
      st   <= st_next;
      slot <= slot_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign read_count        = out_q.read_count;
  assign read_offset       = out_q.read_offset;
  assign packet_started    = out_q.packet_started;
  assign packet_done       = out_q.packet_done;
  assign done_slot         = out_q.done_slot;
  assign done_length       = out_q.done_length;
  assign flush_and_restart = out_q.flush_and_restart;
  assign restart_receive   = out_q.restart_receive;
  assign receiving         = out_q.receiving;

  // an item that moves on always shows up as a result next cycle
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item moved but no result");

  // a completed packet restarts receive and leaves the block listening
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && packet_done) |-> (restart_receive && !receiving && !packet_started))
    else $error("completion result inconsistent");

  // a flush never leaves a reception open
  a_flush_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && flush_and_restart) |-> (!receiving && !packet_done))
    else $error("flush with reception open");

  // offset stays zero when nothing is read
  a_read_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (read_count == '0)) |-> (read_offset == '0))
    else $error("offset given without a read");

endmodule
